// ----- rtl/pcmst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pcmst_pkg;

    // field widths
    localparam int unsigned SampleW  = 16;
    localparam int unsigned ThreshW  = 15;
    localparam int unsigned PadW     = 12;
    localparam int unsigned ScanW    = 16;
    localparam int unsigned CountW   = 20;
    localparam int unsigned LeadW    = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    // largest count the 20-bit length field can hold
    localparam int unsigned CountFieldMax = 1048575;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgKeepPad   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgLeadScan  = 2'd2;

    // register values after reset
    localparam logic [ThreshW-1:0] ThresholdReset = 15'd2;
    localparam logic [PadW-1:0]    KeepPadReset   = 12'd441;
    localparam logic [ScanW-1:0]   LeadScanReset  = 16'd22050;

    // summary of one finished clip, handed from the scan to the bounds stage
    typedef struct packed {
        logic [CountW-1:0] clip_len;
        logic              sound_found;
        logic [LeadW-1:0]  first_sound;
        logic [CountW-1:0] sound_end;
    } clip_sum_t;

endpackage

`default_nettype wire

// ----- rtl/pcmst_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcmst_scan #(
    parameter int unsigned COUNT_CAP = 1048575
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [pcmst_pkg::ThreshW-1:0]    threshold,
    input  wire  [pcmst_pkg::ScanW-1:0]      lead_scan,
    input  wire                              item_valid,
    input  wire  signed [pcmst_pkg::SampleW-1:0] item_sample,
    input  wire                              item_last,
    output logic                             item_ready,
    output logic                             sum_valid,
    output pcmst_pkg::clip_sum_t             sum,
    input  wire                              sum_ready
);

    localparam logic [pcmst_pkg::CountW-1:0] CapValue = pcmst_pkg::CountW'(COUNT_CAP);

    logic [pcmst_pkg::CountW-1:0] count_reg, count_next;
    logic                         found_reg, found_next;
    logic [pcmst_pkg::LeadW-1:0]  first_reg, first_next;
    logic [pcmst_pkg::CountW-1:0] end_reg, end_next;
    logic                         sum_valid_reg;
    pcmst_pkg::clip_sum_t         sum_reg, sum_next;

    logic [pcmst_pkg::SampleW:0]  magnitude;
    logic                         loud;
    logic                         take;
    logic                         sum_free;

    // magnitude of the sample, most negative value gives 32768
    always_comb begin
        if (item_sample[pcmst_pkg::SampleW-1]) begin
            magnitude = (pcmst_pkg::SampleW+1)'(1 << pcmst_pkg::SampleW)
                      - {1'b0, item_sample};
        end else begin
            magnitude = {1'b0, item_sample};
        end
    end

    assign loud = magnitude >= (pcmst_pkg::SampleW+1)'(threshold);

    // a final sample needs room in the summary register
    assign sum_free   = !sum_valid_reg || sum_ready;
    assign item_ready = !item_last || sum_free;
    assign take       = item_valid && item_ready;

    // clip bookkeeping for the sample being taken
    always_comb begin
        count_next = (count_reg < CapValue) ? count_reg + 1'b1 : CapValue;
        found_next = found_reg;
        first_next = first_reg;
        end_next   = end_reg;
        if (loud) begin
            if (!found_reg && count_reg < pcmst_pkg::CountW'(lead_scan)) begin
                found_next = 1'b1;
                first_next = count_reg[pcmst_pkg::LeadW-1:0];
            end
            end_next = count_next;
        end
        sum_next.clip_len    = count_next;
        sum_next.sound_found = found_next;
        sum_next.first_sound = first_next;
        sum_next.sound_end   = end_next;
    end

    // clip state, cleared after each final sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            found_reg <= 1'b0;
            first_reg <= '0;
            end_reg   <= '0;
        end else if (take) begin
            if (item_last) begin
                count_reg <= '0;
                found_reg <= 1'b0;
                first_reg <= '0;
                end_reg   <= '0;
            end else begin
                count_reg <= count_next;
                found_reg <= found_next;
                first_reg <= first_next;
                end_reg   <= end_next;
            end
        end
    end

    // summary register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (take && item_last) begin
            sum_valid_reg <= 1'b1;
        end else if (sum_ready) begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && item_last) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    // last loud position never runs past the sample count
    a_end_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        end_reg <= count_reg)
        else $error("sound end beyond sample count");

    // first sound index stays clear until sound is found
    a_first_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> (first_reg == '0))
        else $error("first sound index set without sound");

    // a final sample taken shows up as a summary in the next cycle
    a_sum_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item_last) |=> sum_valid_reg)
        else $error("final sample lost");

endmodule

`default_nettype wire

// ----- rtl/pcmst_bounds.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcmst_bounds (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire  [pcmst_pkg::PadW-1:0]    keep_pad,
    input  wire  [pcmst_pkg::ScanW-1:0]   lead_scan,
    input  wire                           sum_valid,
    input  pcmst_pkg::clip_sum_t          sum,
    output logic                          sum_ready,
    output logic                          res_valid,
    output logic [pcmst_pkg::LeadW-1:0]   res_lead,
    output logic [pcmst_pkg::CountW-1:0]  res_keep,
    output logic [pcmst_pkg::CountW-1:0]  res_len,
    input  wire                           res_ready
);

    logic                          valid_reg;
    logic [pcmst_pkg::LeadW-1:0]   lead_reg, lead_next;
    logic [pcmst_pkg::CountW-1:0]  keep_reg, keep_next;
    logic [pcmst_pkg::CountW-1:0]  len_reg;
    logic [pcmst_pkg::CountW-1:0]  start;
    logic [pcmst_pkg::CountW-1:0]  pad_ext;
    logic [pcmst_pkg::CountW:0]    end_padded;
    logic                          long_clip;

    assign pad_ext    = pcmst_pkg::CountW'(keep_pad);
    assign long_clip  = sum.clip_len >= {pad_ext[pcmst_pkg::CountW-2:0], 1'b0};
    assign end_padded = {1'b0, sum.sound_end} + {1'b0, pad_ext};

    // leading and trailing bounds of the finished clip
    always_comb begin
        if (sum.sound_found) begin
            start = pcmst_pkg::CountW'(sum.first_sound);
        end else if (sum.clip_len < pcmst_pkg::CountW'(lead_scan)) begin
            start = sum.clip_len;
        end else begin
            start = pcmst_pkg::CountW'(lead_scan);
        end

        lead_next = '0;
        keep_next = sum.clip_len;
        if (long_clip) begin
            if (start != '0 && start < sum.clip_len && start > pad_ext) begin
                lead_next = pcmst_pkg::LeadW'(start - pad_ext);
            end
            if (sum.sound_end != sum.clip_len &&
                end_padded < {1'b0, sum.clip_len}) begin
                keep_next = end_padded[pcmst_pkg::CountW-1:0];
            end
        end
    end

    assign sum_ready = !valid_reg || res_ready;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sum_ready) begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && sum_valid) begin
            lead_reg <= lead_next;
            keep_reg <= keep_next;
            len_reg  <= sum.clip_len;
        end
    end

    assign res_valid = valid_reg;
    assign res_lead  = lead_reg;
    assign res_keep  = keep_reg;
    assign res_len   = len_reg;

    // kept length never exceeds the clip
    a_keep_in_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (keep_reg <= len_reg))
        else $error("tail keep beyond clip length");

    // leading drop stays inside the clip
    a_lead_in_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (pcmst_pkg::CountW'(lead_reg) < len_reg))
        else $error("lead drop beyond clip length");

endmodule

`default_nettype wire

// ----- rtl/pcm_silence_trim_bounds_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata = sample, s_tlast = last sample of clip
// m_       out  m_tvalid/m_tready    m_tdata = lead_drop, tail_keep, clip_length
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// one sample per cycle while no stall holds the input; input register, scan stage, result register
// a clip's bounds are registered in the summary register, then in the result register, after its final sample is taken
// only a final sample waits on a full summary stage; other samples keep flowing
// synchronous active-low reset restores the configuration registers, clears the valid flags and clears clip state
// s_tready is the chain of register-free checks from m_tready back; cfg_ready is tied high

module pcm_silence_trim_bounds_unit #(
    parameter int unsigned MAX_CLIP_SAMPLES = 1048575
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // [15:0] lead_drop, [35:16] tail_keep, [55:36] clip_length
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [pcmst_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire  [pcmst_pkg::CfgDataW-1:0] cfg_data
);

    localparam int unsigned CountCap =
        (MAX_CLIP_SAMPLES < pcmst_pkg::CountFieldMax) ? MAX_CLIP_SAMPLES
                                                      : pcmst_pkg::CountFieldMax;

    logic [pcmst_pkg::ThreshW-1:0] thresh_reg;
    logic [pcmst_pkg::PadW-1:0]    pad_reg;
    logic [pcmst_pkg::ScanW-1:0]   scan_reg;

    logic                          in_valid_reg;
    logic signed [pcmst_pkg::SampleW-1:0] in_sample_reg;
    logic                          in_last_reg;
    logic                          in_ready;

    logic                          sum_valid;
    logic                          sum_ready;
    pcmst_pkg::clip_sum_t          sum;

    logic [pcmst_pkg::LeadW-1:0]   res_lead;
    logic [pcmst_pkg::CountW-1:0]  res_keep;
    logic [pcmst_pkg::CountW-1:0]  res_len;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= pcmst_pkg::ThresholdReset;
            pad_reg    <= pcmst_pkg::KeepPadReset;
            scan_reg   <= pcmst_pkg::LeadScanReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pcmst_pkg::CfgThreshold: thresh_reg <= cfg_data[pcmst_pkg::ThreshW-1:0];
                pcmst_pkg::CfgKeepPad:   pad_reg    <= cfg_data[pcmst_pkg::PadW-1:0];
                pcmst_pkg::CfgLeadScan:  scan_reg   <= cfg_data[pcmst_pkg::ScanW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign s_tready = !in_valid_reg || in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
    end

    // sample scan and clip state
    pcmst_scan #(
        .COUNT_CAP (CountCap)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .threshold   (thresh_reg),
        .lead_scan   (scan_reg),
        .item_valid  (in_valid_reg),
        .item_sample (in_sample_reg),
        .item_last   (in_last_reg),
        .item_ready  (in_ready),
        .sum_valid   (sum_valid),
        .sum         (sum),
        .sum_ready   (sum_ready)
    );

    // trim bounds and result register
    pcmst_bounds u_bounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .keep_pad  (pad_reg),
        .lead_scan (scan_reg),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_ready (sum_ready),
        .res_valid (m_tvalid),
        .res_lead  (res_lead),
        .res_keep  (res_keep),
        .res_len   (res_len),
        .res_ready (m_tready)
    );

    assign m_tdata = {res_len, res_keep, res_lead};

endmodule

`default_nettype wire

// ----- bench/pcm_silence_trim_bounds_unit_tb.sv -----
`timescale 1ns / 1ps

module pcm_silence_trim_bounds_unit_tb;

    // count cap below the field maximum
    localparam int unsigned ClipCap   = 9000;
    localparam int unsigned CycleMax  = 1000000;
    localparam int unsigned TailWait  = 8;

    // bounds of one finished clip
    typedef struct packed {
        logic [pcmst_pkg::LeadW-1:0]  lead_drop;
        logic [pcmst_pkg::CountW-1:0] tail_keep;
        logic [pcmst_pkg::CountW-1:0] clip_length;
    } bounds_t;

    // tracks the trim bounds of the current clip and the bounds still owed
    class trim_bounds_board;
        int unsigned threshold;
        int unsigned keep_pad;
        int unsigned lead_scan;
        int unsigned sample_pos;
        bit          heard;
        int unsigned first_loud;
        int unsigned loud_end;
        bounds_t     bounds_q[$];
        int          errors;

        function new();
            threshold    = pcmst_pkg::ThresholdReset;
            keep_pad     = pcmst_pkg::KeepPadReset;
            lead_scan    = pcmst_pkg::LeadScanReset;
            errors       = 0;
            clear_clip();
        endfunction

        function void clear_clip();
            sample_pos = 0;
            heard      = 1'b0;
            first_loud = 0;
            loud_end   = 0;
        endfunction

        function void write_reg(logic [pcmst_pkg::CfgIdxW-1:0] idx,
                                logic [pcmst_pkg::CfgDataW-1:0] value);
            case (idx)
                pcmst_pkg::CfgThreshold: threshold = value & 16'h7FFF;
                pcmst_pkg::CfgKeepPad:   keep_pad  = value & 16'h0FFF;
                pcmst_pkg::CfgLeadScan:  lead_scan = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return bounds_q.size();
        endfunction

        // one accepted sample; a final sample closes the clip
        function void note_sample(logic [pcmst_pkg::SampleW-1:0] pcm, logic last);
            int unsigned mag;
            int unsigned pos;
            int unsigned len;
            int unsigned start;
            int unsigned lead;
            int unsigned keep;
            int unsigned pad_end;
            int unsigned cap;
            bounds_t     b;
            mag = pcm[15] ? (32'h10000 - 32'(pcm)) : 32'(pcm);
            cap = (ClipCap < pcmst_pkg::CountFieldMax) ? ClipCap : pcmst_pkg::CountFieldMax;
            pos = sample_pos;
            sample_pos = (sample_pos < cap) ? sample_pos + 1 : cap;
            if (mag >= threshold) begin
                if (!heard && pos < lead_scan) begin
                    heard      = 1'b1;
                    first_loud = pos & 16'hFFFF;
                end
                loud_end = sample_pos;
            end
            if (!last) return;
            len  = sample_pos;
            lead = 0;
            keep = len;
            // short clips are left untrimmed
            if (len >= 2 * keep_pad) begin
                if (heard) start = first_loud;
                else start = (len < lead_scan) ? len : lead_scan;
                if (start != 0 && start < len)
                    lead = (start > keep_pad) ? start - keep_pad : 0;
                if (loud_end != len) begin
                    pad_end = loud_end + keep_pad;
                    keep = (pad_end < len) ? pad_end : len;
                end
            end
            b.lead_drop   = lead[pcmst_pkg::LeadW-1:0];
            b.tail_keep   = keep[pcmst_pkg::CountW-1:0];
            b.clip_length = len[pcmst_pkg::CountW-1:0];
            bounds_q = {bounds_q, b};
            clear_clip();
        endfunction

        // compare one result against the oldest owed bounds
        function void check_result(logic [55:0] word);
            bounds_t want;
            if (bounds_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            want = bounds_q[0];
            bounds_q.delete(0);
            if (word[15:0] !== want.lead_drop) begin
                $display("%0t: lead_drop expected %0d actual %0d",
                         $time, want.lead_drop, word[15:0]);
                errors++;
            end
            if (word[35:16] !== want.tail_keep) begin
                $display("%0t: tail_keep expected %0d actual %0d",
                         $time, want.tail_keep, word[35:16]);
                errors++;
            end
            if (word[55:36] !== want.clip_length) begin
                $display("%0t: clip_length expected %0d actual %0d",
                         $time, want.clip_length, word[55:36]);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [55:0]         m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [pcmst_pkg::CfgIdxW-1:0]  cfg_index = pcmst_pkg::CfgThreshold;
    logic [pcmst_pkg::CfgDataW-1:0] cfg_data = '0;

    trim_bounds_board sb = new();
    logic [15:0] pcm_q[$];
    int          sent_total = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          rx_tick = 0;

    pcm_silence_trim_bounds_unit #(
        .MAX_CLIP_SAMPLES(ClipCap)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleMax) begin
            $display("[pcm_silence_trim_bounds_unit] ERROR");
            $finish;
        end
    end

    // result side stalls on a rotating pattern
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        case (rx_tick[9:7])
            3'd0, 3'd1: m_tready <= 1'b1;
            3'd2:       m_tready <= rx_tick[0];
            3'd3:       m_tready <= ($urandom_range(0, 3) == 0);
            3'd4:       m_tready <= (rx_tick[4:0] > 5'd20);
            default:    m_tready <= $urandom_range(0, 1);
        endcase
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic pause_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // one sample request, then a gap when the current burst runs out
    task automatic push_sample(input logic [15:0] pcm, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= pcm;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(pcm, last);
        sent_total++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            pause_sender($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_clip();
        logic [15:0] pcm;
        while (pcm_q.size() != 0) begin
            pcm = pcm_q[0];
            pcm_q.delete(0);
            push_sample(pcm, pcm_q.size() == 0);
        end
    endtask

    // hold the sender until every owed result is out and the pipe is empty
    task automatic drain_results();
        pause_sender(1);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (TailWait) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [pcmst_pkg::CfgIdxW-1:0] idx,
                             input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] quiet_pcm(input int unsigned thr);
        int v;
        if (thr == 0) return 16'h0000;
        v = $urandom_range(0, thr - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
        return v[15:0];
    endfunction

    function automatic logic [15:0] loud_pcm(input int unsigned thr);
        int v;
        case ($urandom_range(0, 5))
            0:       v = thr;
            1:       v = -int'(thr);
            2:       v = -32768;
            3:       v = 32767;
            default: begin
                v = $urandom_range(thr, 32767);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v[15:0];
    endfunction

    // silence, a sound body, silence, or else raw noise; sized around the pad and scan limit
    task automatic send_shaped_clip();
        int unsigned lead_sil;
        int unsigned body;
        int unsigned tail_sil;
        int unsigned lim_lead;
        int unsigned lim_tail;
        int unsigned style;
        style    = $urandom_range(0, 9);
        lim_lead = (sb.lead_scan < 30) ? sb.lead_scan + 3 : 30;
        lim_tail = (sb.keep_pad < 20) ? sb.keep_pad + 3 : 20;
        if (style == 9) begin
            // raw noise
            repeat ($urandom_range(1, 30)) pcm_q = {pcm_q, 16'($urandom)};
        end else begin
            lead_sil = $urandom_range(0, lim_lead);
            body     = (style == 0) ? 0 : $urandom_range(1, 12);
            tail_sil = $urandom_range(0, lim_tail);
            if (lead_sil + body + tail_sil == 0) lead_sil = 1;
            repeat (lead_sil) pcm_q = {pcm_q, quiet_pcm(sb.threshold)};
            repeat (body) begin
                if ($urandom_range(0, 4) == 0) pcm_q = {pcm_q, quiet_pcm(sb.threshold)};
                else pcm_q = {pcm_q, loud_pcm(sb.threshold)};
            end
            repeat (tail_sil) pcm_q = {pcm_q, quiet_pcm(sb.threshold)};
        end
        send_clip();
    endtask

    task automatic retune();
        case ($urandom_range(0, 5))
            0:       write_reg(pcmst_pkg::CfgThreshold, 16'd0);
            1:       write_reg(pcmst_pkg::CfgThreshold, 16'd1);
            2:       write_reg(pcmst_pkg::CfgThreshold, 16'd32767);
            3:       write_reg(pcmst_pkg::CfgThreshold, 16'($urandom_range(2, 300)));
            4:       write_reg(pcmst_pkg::CfgThreshold, 16'($urandom));
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0:       write_reg(pcmst_pkg::CfgKeepPad, 16'd0);
            1:       write_reg(pcmst_pkg::CfgKeepPad, 16'd1);
            2, 3:    write_reg(pcmst_pkg::CfgKeepPad, 16'($urandom_range(2, 8)));
            4:       write_reg(pcmst_pkg::CfgKeepPad, 16'd4095);
            5:       write_reg(pcmst_pkg::CfgKeepPad, 16'($urandom));
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0:       write_reg(pcmst_pkg::CfgLeadScan, 16'd0);
            1:       write_reg(pcmst_pkg::CfgLeadScan, 16'd1);
            2, 3:    write_reg(pcmst_pkg::CfgLeadScan, 16'($urandom_range(2, 30)));
            4:       write_reg(pcmst_pkg::CfgLeadScan, 16'd65535);
            5:       write_reg(pcmst_pkg::CfgLeadScan, 16'($urandom));
            default: ;
        endcase
    endtask

    initial begin
        int rand_base;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: threshold hit exactly on a negative sample, short clip
        pcm_q = '{16'sd1, -16'sd1, -16'sd2};
        send_clip();
        drain_results();

        write_reg(pcmst_pkg::CfgThreshold, 16'd100);
        write_reg(pcmst_pkg::CfgKeepPad, 16'd2);
        write_reg(pcmst_pkg::CfgLeadScan, 16'd6);
        // most negative sample first: no leading trim
        pcm_q = '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767};
        send_clip();
        // silent clip no longer than the scan limit
        pcm_q = '{16'sd0, 16'sd99, -16'sd99, 16'sd0, 16'sd1};
        send_clip();
        // silent clip longer than the scan limit
        pcm_q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        send_clip();
        // length exactly twice the pad, sound on the last sample
        pcm_q = '{16'sd0, 16'sd0, 16'sd0, -16'sd100};
        send_clip();

        // random phases with fresh settings between them
        rand_base = sent_total;
        while ((sent_total - rand_base) < 680) begin
            drain_results();
            retune();
            repeat ($urandom_range(2, 8)) send_shaped_clip();
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("[pcm_silence_trim_bounds_unit] OK");
        end else begin
            $display("[pcm_silence_trim_bounds_unit] ERROR");
        end
        $finish;
    end

endmodule
